FILE: design/nested_context_time_accounting_defines.svh
// ----------------------------------------------------------------------------
// Nested context time accounting: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NESTED_CONTEXT_TIME_ACCOUNTING_DEFINES_SVH
`define NESTED_CONTEXT_TIME_ACCOUNTING_DEFINES_SVH

// Check sampled on the rising clock edge, switched off while reset is held.
`define NCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on the rising clock edge, live during reset as well.
`define NCT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/nct_pkg.sv
// ----------------------------------------------------------------------------
// Nested context time accounting: shared package
// Sizes, command codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam int NUM_CONTEXTS = 5;
  localparam int STACK_DEPTH  = 9;

  localparam int CMD_W   = 2;
  localparam int CTX_W   = 3;
  localparam int TOTAL_W = 32;

  // Stack pointer never exceeds STACK_DEPTH - 1, so it doubles as the index.
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int IDX_W = $clog2(NUM_CONTEXTS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ENTER  = 2'd1,
    CMD_LEAVE  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  // One decoded command waiting for the execution side.
  typedef struct packed {
    cmd_t             cmd;
    logic [CTX_W-1:0] ctx;
    logic             bad_ctx;
  } op_t;

endpackage

FILE: design/nct_front.sv
// ----------------------------------------------------------------------------
// Nested context time accounting: front end
// Accepts command beats, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
module nct_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: cmd[1:0], context_id[4:2], zero fill[7:5].
  input  logic [nct_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           q_valid,
  output nct_pkg::op_t                   q_item,
  input  logic                           q_pop
);
  import nct_pkg::*;

  op_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  op_t               decoded;

  // Decode the incoming beat and flag an out-of-range context up front.
  always_comb begin
    decoded.cmd     = cmd_t'(in_tdata[CMD_W-1:0]);
    decoded.ctx     = in_tdata[CMD_W +: CTX_W];
    decoded.bad_ctx = (int'(in_tdata[CMD_W +: CTX_W]) >= NUM_CONTEXTS);
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

FILE: design/nct_exec.sv
// ----------------------------------------------------------------------------
// Nested context time accounting: execution back end
// Keeps the tick counter, context stack and totals, and drives result beats.
// ----------------------------------------------------------------------------
module nct_exec (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  nct_pkg::op_t                    q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: entry_context[2:0], total_ticks[34:3], error[35],
  // zero fill[39:36].
  output logic [nct_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // Field: kind[0].
  output logic                            out_tuser
);
  import nct_pkg::*;

  logic [CTX_W-1:0]   cur_r, cur_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [SP_W-1:0]    sp_dec;
  logic [CTX_W-1:0]   stack_r [STACK_DEPTH];
  logic               stack_we;
  logic [TOTAL_W-1:0] totals_r [NUM_CONTEXTS];
  logic [TOTAL_W-1:0] totals_nxt [NUM_CONTEXTS];
  logic [TOTAL_W-1:0] elapsed_r, elapsed_nxt;
  logic               rpt_active_r, rpt_active_nxt;
  logic [IDX_W-1:0]   rpt_idx_r, rpt_idx_nxt;
  logic [IDX_W-1:0]   emit_idx;
  logic               emit_entry;
  logic               charge;
  logic               load;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [CTX_W-1:0]   entry_ctx_r, entry_ctx_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               last_r, last_nxt;
  logic               err_r, err_nxt;

  assign sp_dec = sp_r - SP_W'(1);
  assign load   = !out_valid_r || out_tready;

  // Command execution and report walk.
  always_comb begin
    cur_nxt        = cur_r;
    sp_nxt         = sp_r;
    elapsed_nxt    = elapsed_r;
    rpt_active_nxt = rpt_active_r;
    rpt_idx_nxt    = rpt_idx_r;
    totals_nxt     = totals_r;
    stack_we       = 1'b0;
    q_pop          = 1'b0;
    charge         = 1'b0;
    emit_entry     = 1'b0;
    emit_idx       = rpt_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    kind_nxt       = kind_r;
    entry_ctx_nxt  = entry_ctx_r;
    total_nxt      = total_r;
    last_nxt       = last_r;
    err_nxt        = err_r;

    if (load) begin
      if (rpt_active_r) begin
        emit_entry = 1'b1;
      end else if (q_valid) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        kind_nxt      = 1'b0;
        entry_ctx_nxt = '0;
        total_nxt     = '0;
        last_nxt      = 1'b1;
        err_nxt       = 1'b0;
        unique case (q_item.cmd)
          CMD_TICK: begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
          CMD_ENTER: begin
            if (q_item.bad_ctx || (sp_r >= SP_W'(STACK_DEPTH - 1))) begin
              err_nxt = 1'b1;
            end else begin
              charge   = 1'b1;
              stack_we = 1'b1;
              sp_nxt   = sp_r + 1'b1;
              cur_nxt  = q_item.ctx;
            end
          end
          CMD_LEAVE: begin
            if (sp_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              charge  = 1'b1;
              sp_nxt  = sp_dec;
              cur_nxt = stack_r[sp_dec];
            end
          end
          CMD_REPORT: begin
            emit_entry = 1'b1;
            emit_idx   = '0;
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
    end

    // Charge the elapsed count to the running context.
    if (charge) begin
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        if (int'(cur_r) == i) begin
          totals_nxt[i] = totals_r[i] + elapsed_r;
        end
      end
      elapsed_nxt = '0;
    end

    // A report entry shows the head total and shifts the rest down,
    // clearing each total as it leaves.
    if (emit_entry) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = 1'b1;
      entry_ctx_nxt = CTX_W'(emit_idx);
      total_nxt     = totals_r[0];
      err_nxt       = 1'b0;
      last_nxt      = (emit_idx == IDX_W'(NUM_CONTEXTS - 1));
      for (int i = 0; i < NUM_CONTEXTS - 1; i++) begin
        totals_nxt[i] = totals_r[i + 1];
      end
      totals_nxt[NUM_CONTEXTS - 1] = '0;
      if (emit_idx == IDX_W'(NUM_CONTEXTS - 1)) begin
        rpt_active_nxt = 1'b0;
      end else begin
        rpt_active_nxt = 1'b1;
        rpt_idx_nxt    = emit_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      sp_r         <= '0;
      elapsed_r    <= '0;
      totals_r     <= '{default: '0};
      rpt_active_r <= 1'b0;
      rpt_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_r        <= cur_nxt;
      sp_r         <= sp_nxt;
      elapsed_r    <= elapsed_nxt;
      totals_r     <= totals_nxt;
      rpt_active_r <= rpt_active_nxt;
      rpt_idx_r    <= rpt_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload and stack contents carry no reset.
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    entry_ctx_r <= entry_ctx_nxt;
    total_r     <= total_nxt;
    last_r      <= last_nxt;
    err_r       <= err_nxt;
    if (stack_we) begin
      stack_r[sp_r] <= cur_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - CTX_W - TOTAL_W - 1)'(0), err_r, total_r, entry_ctx_r};
  assign out_tlast  = last_r;
  assign out_tuser  = kind_r;

endmodule

FILE: design/nested_context_time_accounting.sv
// An accepted command beat waits in the front queue until the back end takes it into the
// registered result beat. Throughput: one tick, enter or leave per cycle while the output
// is not stalled and no report runs; a report emits NUM_CONTEXTS entries, one report entry
// per cycle unless stalled, while the front queue keeps filling. Reset: synchronous;
// clears totals, tick counter, stack pointer, current context, not stack contents.
// ----------------------------------------------------------------------------
// Nested context time accounting: top level
// Per-context tick profiler with a decoupled command queue and execution unit.
// ----------------------------------------------------------------------------
`include "nested_context_time_accounting_defines.svh"

module nested_context_time_accounting (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: cmd[1:0], context_id[4:2], zero fill[7:5].
  input  logic [nct_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: entry_context[2:0], total_ticks[34:3], error[35],
  // zero fill[39:36].
  output logic [nct_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // Field: kind[0].
  output logic                            out_tuser
);
  import nct_pkg::*;

  logic q_valid;
  logic q_pop;
  op_t  q_item;

  // Front end: accept and decode command beats.
  nct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Back end: execute commands and produce result beats.
  nct_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Every status beat closes its own run.
  `NCT_ASSERT(a_status_last, out_tvalid && !out_tuser |-> out_tlast, "status beat without tlast")
  // A report entry never carries an error.
  `NCT_ASSERT(a_report_no_err, out_tvalid && out_tuser |-> !out_tdata[35], "error on report entry")
  // The closing report entry belongs to the highest context.
  `NCT_ASSERT(a_report_end, out_tvalid && out_tuser && out_tlast |-> out_tdata[2:0] == CTX_W'(NUM_CONTEXTS - 1), "report closed at wrong context")
  // No result is pending right after reset.
  `NCT_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule
